/* design/gct_pkg.sv */
// ----------------------------------------------------------------------------
// gct_pkg
// Shared types, widths and codes for the grid cell triangulator.
// ----------------------------------------------------------------------------
package gct_pkg;

  // payload widths
  localparam int HEIGHT_W  = 16;
  localparam int CLASS_W   = 8;
  localparam int IDX_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 11;
  localparam int GEOM_W    = 11;

  // default geometry limits
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_ROWS_DEF  = 1024;

  // cell queue depth
  localparam int QUEUE_DEPTH = 4;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH       = 3'd0,
    REG_ROW_COUNT       = 3'd1,
    REG_COMPACT_SPLIT   = 3'd2,
    REG_CLASS_RULE      = 3'd3,
    REG_CLASSES_PRESENT = 3'd4
  } gct_reg_e;

  // class reduction rules
  typedef enum logic [1:0] {
    CLS_MIN     = 2'd0,
    CLS_MAX     = 2'd1,
    CLS_MAJ_MIN = 2'd2,
    CLS_MAJ_MAX = 2'd3
  } gct_rule_e;

  typedef struct packed {
    logic [GEOM_W-1:0] row_width;
    logic [GEOM_W-1:0] row_count;
    logic              compact_split;
  } gct_geom_t;

  typedef struct packed {
    gct_rule_e rule;
    logic      present;
  } gct_cls_ctrl_t;

  // one closed grid cell, as queued between front and back
  typedef struct packed {
    logic [IDX_W-1:0]   p3;
    logic [IDX_W-1:0]   p1;
    logic               split_03;
    logic [CLASS_W-1:0] f0;
    logic [CLASS_W-1:0] f1;
    logic [CLASS_W-1:0] f2;
    logic [CLASS_W-1:0] f3;
    logic               fend;
  } gct_cell_t;

  typedef struct packed {
    logic room1;
    logic room2;
  } gct_qstat_t;

endpackage

/* design/gct_in_if.sv */
// ----------------------------------------------------------------------------
// gct_in_if
// Sample request channel: height and class of one grid point.
// ----------------------------------------------------------------------------
interface gct_in_if;
  import gct_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] height;
  logic [CLASS_W-1:0]         sample_class;

  modport source (output valid, output height, output sample_class, input ready);
  modport sink   (input valid, input height, input sample_class, output ready);

endinterface

/* design/gct_out_if.sv */
// ----------------------------------------------------------------------------
// gct_out_if
// Triangle request channel: three point indices, class and end flags.
// ----------------------------------------------------------------------------
interface gct_out_if;
  import gct_pkg::*;

  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   vertex_a;
  logic [IDX_W-1:0]   vertex_b;
  logic [IDX_W-1:0]   vertex_c;
  logic [CLASS_W-1:0] triangle_class;
  logic               pair_end;
  logic               frame_end;

  modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                  output triangle_class, output pair_end, output frame_end,
                  input ready);
  modport sink   (input valid, input vertex_a, input vertex_b, input vertex_c,
                  input triangle_class, input pair_end, input frame_end,
                  output ready);

endinterface

/* design/gct_cfg_if.sv */
// ----------------------------------------------------------------------------
// gct_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gct_cfg_if;
  import gct_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);

endinterface

/* design/gct_fifo.sv */
// ----------------------------------------------------------------------------
// gct_fifo
// Short cell queue between the sample front and the triangle back.
// ----------------------------------------------------------------------------
module gct_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gct_pkg::gct_cell_t  push_data,
  input  logic                pop,
  output gct_pkg::gct_cell_t  head,
  output logic                head_valid,
  output gct_pkg::gct_qstat_t qstat
);
  import gct_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ROOM1_MAX = CW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM2_MAX = CW'(DEPTH - 2);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  gct_cell_t       store_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign head        = store_r[rd_ptr_r];
  assign head_valid  = (count_r != '0);
  assign qstat.room1 = (count_r <= ROOM1_MAX);
  assign qstat.room2 = (count_r <= ROOM2_MAX);

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> count_r != FULL_CNT)
    else $error("cell queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("cell queue read while empty");

endmodule

/* design/gct_front.sv */
// ----------------------------------------------------------------------------
// gct_front
// Accepts samples, tracks the raster position, keeps the row above and
// classifies each closed cell (diagonal, indices, corner classes).
// ----------------------------------------------------------------------------
module gct_front #(
  parameter int MAX_WIDTH = gct_pkg::MAX_WIDTH_DEF,
  parameter int MAX_ROWS  = gct_pkg::MAX_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  gct_in_if.sink              in_chan,
  input  gct_pkg::gct_geom_t  geom,
  input  logic                restart,
  input  gct_pkg::gct_qstat_t qstat,
  output logic                push,
  output gct_pkg::gct_cell_t  push_data
);
  import gct_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int SW = HEIGHT_W + 1;

  // row store, one word per column
  logic [CLASS_W+HEIGHT_W-1:0] row_mem [MAX_WIDTH];
  logic [CLASS_W+HEIGHT_W-1:0] above_r;

  logic [AW-1:0]    col_r;
  logic [RW-1:0]    row_r;
  logic [IDX_W-1:0] idx_r;

  logic signed [HEIGHT_W-1:0] left_h_r;
  logic [CLASS_W-1:0]         left_c_r;
  logic signed [HEIGHT_W-1:0] corner_h_r;
  logic [CLASS_W-1:0]         corner_c_r;

  // stage one: accepted sample waiting for its row store word
  logic                       s1_valid_r;
  logic signed [HEIGHT_W-1:0] s1_h3_r;
  logic [CLASS_W-1:0]         s1_f3_r;
  logic signed [HEIGHT_W-1:0] s1_h2_r;
  logic [CLASS_W-1:0]         s1_f2_r;
  logic [IDX_W-1:0]           s1_p3_r;
  logic                       s1_emit_r;
  logic                       s1_fend_r;

  logic [EW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic          accept;
  logic          last_col;
  logic          last_row;

  logic signed [HEIGHT_W-1:0] z1;
  logic [CLASS_W-1:0]         f1;
  logic signed [SW-1:0]       sum_03;
  logic signed [SW-1:0]       sum_12;

  always_comb begin
    if (geom.row_width < GEOM_W'(2)) begin
      eff_w = EW'(2);
    end else if (32'(geom.row_width) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(geom.row_width);
    end
    if (geom.row_count < GEOM_W'(2)) begin
      eff_h = HW'(2);
    end else if (32'(geom.row_count) > 32'(MAX_ROWS)) begin
      eff_h = HW'(MAX_ROWS);
    end else begin
      eff_h = HW'(geom.row_count);
    end
  end

  // a stage-one sample may still push, so keep room for it
  assign in_chan.ready = s1_valid_r ? qstat.room2 : qstat.room1;
  assign accept        = in_chan.valid && in_chan.ready;
  assign last_col      = ((EW'(col_r) + EW'(1)) == eff_w);
  assign last_row      = ((HW'(row_r) + HW'(1)) == eff_h);

  // read before write at the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      row_mem[col_r] <= {in_chan.sample_class, in_chan.height};
      above_r        <= row_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_h3_r   <= in_chan.height;
      s1_f3_r   <= in_chan.sample_class;
      s1_h2_r   <= left_h_r;
      s1_f2_r   <= left_c_r;
      s1_p3_r   <= idx_r;
      s1_emit_r <= (row_r != '0) && (col_r != '0);
      s1_fend_r <= last_row && last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      idx_r      <= '0;
      s1_valid_r <= 1'b0;
      left_h_r   <= '0;
      left_c_r   <= '0;
      corner_h_r <= '0;
      corner_c_r <= '0;
    end else begin
      s1_valid_r <= accept;
      if (restart) begin
        col_r <= '0;
        row_r <= '0;
        idx_r <= '0;
      end else if (accept) begin
        left_h_r <= in_chan.height;
        left_c_r <= in_chan.sample_class;
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + RW'(1);
          idx_r <= last_row ? '0 : idx_r + IDX_W'(1);
        end else begin
          col_r <= col_r + AW'(1);
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      if (s1_valid_r) begin
        corner_h_r <= z1;
        corner_c_r <= f1;
      end
    end
  end

  // stage two: cell classification
  assign z1     = above_r[HEIGHT_W-1:0];
  assign f1     = above_r[CLASS_W+HEIGHT_W-1:HEIGHT_W];
  assign sum_03 = $signed({corner_h_r[HEIGHT_W-1], corner_h_r})
                + $signed({s1_h3_r[HEIGHT_W-1], s1_h3_r});
  assign sum_12 = $signed({s1_h2_r[HEIGHT_W-1], s1_h2_r})
                + $signed({z1[HEIGHT_W-1], z1});

  assign push               = s1_valid_r && s1_emit_r;
  assign push_data.p3       = s1_p3_r;
  assign push_data.p1       = s1_p3_r - IDX_W'(eff_w);
  assign push_data.split_03 = geom.compact_split || (sum_03 <= sum_12);
  assign push_data.f0       = corner_c_r;
  assign push_data.f1       = f1;
  assign push_data.f2       = s1_f2_r;
  assign push_data.f3       = s1_f3_r;
  assign push_data.fend     = s1_fend_r;

endmodule

/* design/gct_back.sv */
// ----------------------------------------------------------------------------
// gct_back
// Emits the two triangles of each queued cell and reduces their classes.
// ----------------------------------------------------------------------------
module gct_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gct_pkg::gct_cell_t    head,
  input  logic                  head_valid,
  output logic                  pop,
  input  gct_pkg::gct_cls_ctrl_t cls_ctrl,
  gct_out_if.source             out_chan
);
  import gct_pkg::*;

  typedef enum logic {
    HALF_FIRST,
    HALF_SECOND
  } half_t;

  function automatic logic [CLASS_W-1:0] reduce_class(
    input gct_cls_ctrl_t       ctl,
    input logic [CLASS_W-1:0]  a,
    input logic [CLASS_W-1:0]  b,
    input logic [CLASS_W-1:0]  c
  );
    logic [CLASS_W-1:0] lo;
    logic [CLASS_W-1:0] hi;
    logic               maj;
    logic               take_max;
    logic [CLASS_W-1:0] res;
    maj      = (ctl.rule == CLS_MAJ_MIN) || (ctl.rule == CLS_MAJ_MAX);
    take_max = (ctl.rule == CLS_MAX) || (ctl.rule == CLS_MAJ_MAX);
    lo = (a < b) ? a : b;
    lo = (lo < c) ? lo : c;
    hi = (a > b) ? a : b;
    hi = (hi > c) ? hi : c;
    res = take_max ? hi : lo;
    if (maj && ((a == b) || (a == c))) begin
      res = a;
    end else if (maj && (b == c)) begin
      res = b;
    end
    if (!ctl.present) begin
      res = '0;
    end
    return res;
  endfunction

  half_t              half_r;
  logic               out_valid_r;
  logic [IDX_W-1:0]   va_r;
  logic [IDX_W-1:0]   vb_r;
  logic [IDX_W-1:0]   vc_r;
  logic [CLASS_W-1:0] cls_r;
  logic               pair_r;
  logic               fend_r;

  logic               load;
  logic [IDX_W-1:0]   p0;
  logic [IDX_W-1:0]   p2;
  logic [IDX_W-1:0]   va_nxt;
  logic [IDX_W-1:0]   vb_nxt;
  logic [IDX_W-1:0]   vc_nxt;
  logic [CLASS_W-1:0] cls_nxt;

  assign load = !out_valid_r || out_chan.ready;
  assign pop  = load && head_valid && (half_r == HALF_SECOND);
  assign p0   = head.p1 - IDX_W'(1);
  assign p2   = head.p3 - IDX_W'(1);

  always_comb begin
    if (half_r == HALF_FIRST) begin
      va_nxt = p2;
      vb_nxt = head.split_03 ? head.p3 : head.p1;
      vc_nxt = p0;
      cls_nxt = head.split_03 ? reduce_class(cls_ctrl, head.f2, head.f3, head.f0)
                              : reduce_class(cls_ctrl, head.f2, head.f1, head.f0);
    end else begin
      va_nxt = head.p1;
      vb_nxt = head.split_03 ? p0 : p2;
      vc_nxt = head.p3;
      cls_nxt = head.split_03 ? reduce_class(cls_ctrl, head.f1, head.f0, head.f3)
                              : reduce_class(cls_ctrl, head.f1, head.f2, head.f3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= HALF_FIRST;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) begin
        va_r   <= va_nxt;
        vb_r   <= vb_nxt;
        vc_r   <= vc_nxt;
        cls_r  <= cls_nxt;
        pair_r <= (half_r == HALF_SECOND);
        fend_r <= (half_r == HALF_SECOND) && head.fend;
        unique case (half_r)
          HALF_FIRST:  half_r <= HALF_SECOND;
          HALF_SECOND: half_r <= HALF_FIRST;
          default:     half_r <= HALF_FIRST;
        endcase
      end
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.vertex_a       = va_r;
  assign out_chan.vertex_b       = vb_r;
  assign out_chan.vertex_c       = vc_r;
  assign out_chan.triangle_class = cls_r;
  assign out_chan.pair_end       = pair_r;
  assign out_chan.frame_end      = fend_r;

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_chan.ready && !pair_r |=> out_valid_r && pair_r)
    else $error("first triangle of a cell not followed by its second");

  a_fend_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && fend_r |-> pair_r)
    else $error("frame end on a first triangle");

endmodule

/* design/grid_cell_triangulator.sv */
// ----------------------------------------------------------------------------
// grid_cell_triangulator
// Raster height grid to triangle list, two triangles per closed grid cell.
// ----------------------------------------------------------------------------
// Samples enter in raster order; every sample past the first row and first
// column closes a cell and yields two triangles, one per cycle on the result
// channel while it is ready, from the output register. Samples of the first
// row and column give no triangles. The front accepts a sample every cycle
// while the four-entry cell queue has room; a sample's first triangle passes
// through the stage-one register, the cell queue and the output register. No
// clearing pass: the row store is only read at columns written earlier in the
// same frame. Writing row_width or row_count restarts the frame at row 0,
// column 0.
// ----------------------------------------------------------------------------
module grid_cell_triangulator #(
  parameter int MAX_WIDTH = gct_pkg::MAX_WIDTH_DEF,
  parameter int MAX_ROWS  = gct_pkg::MAX_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gct_in_if.sink     in_chan,
  gct_out_if.source  out_chan,
  gct_cfg_if.sink    cfg_chan
);
  import gct_pkg::*;

  // configuration registers
  logic [GEOM_W-1:0] row_width_r;
  logic [GEOM_W-1:0] row_count_r;
  logic              compact_split_r;
  gct_rule_e         class_rule_r;
  logic              classes_present_r;

  logic          cfg_fire;
  logic          restart;
  gct_geom_t     geom;
  gct_cls_ctrl_t cls_ctrl;

  // queue hookup
  logic       push;
  gct_cell_t  push_data;
  logic       pop;
  gct_cell_t  head;
  logic       head_valid;
  gct_qstat_t qstat;

  // writes are always taken
  assign cfg_chan.ready = 1'b1;
  assign cfg_fire       = cfg_chan.valid && cfg_chan.ready;

  // geometry writes restart the raster position
  assign restart = cfg_fire &&
                   ((cfg_chan.index == REG_ROW_WIDTH) || (cfg_chan.index == REG_ROW_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r       <= GEOM_W'(2);
      row_count_r       <= GEOM_W'(2);
      compact_split_r   <= 1'b0;
      class_rule_r      <= CLS_MIN;
      classes_present_r <= 1'b0;
    end else if (cfg_fire) begin
      unique case (gct_reg_e'(cfg_chan.index))
        REG_ROW_WIDTH:       row_width_r       <= cfg_chan.data;
        REG_ROW_COUNT:       row_count_r       <= cfg_chan.data;
        REG_COMPACT_SPLIT:   compact_split_r   <= cfg_chan.data[0];
        REG_CLASS_RULE:      class_rule_r      <= gct_rule_e'(cfg_chan.data[1:0]);
        REG_CLASSES_PRESENT: classes_present_r <= cfg_chan.data[0];
        default: ; // writes beyond the register list are dropped
      endcase
    end
  end

  assign geom.row_width     = row_width_r;
  assign geom.row_count     = row_count_r;
  assign geom.compact_split = compact_split_r;
  assign cls_ctrl.rule      = class_rule_r;
  assign cls_ctrl.present   = classes_present_r;

  // front: position tracking, row store, cell classification
  gct_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_ROWS  (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .geom      (geom),
    .restart   (restart),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  // cell queue decouples sample intake from triangle output
  gct_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .qstat      (qstat)
  );

  // back: two triangles per cell, class reduction, output register
  gct_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .cls_ctrl   (cls_ctrl),
    .out_chan   (out_chan)
  );

endmodule
